// ===== src/rbf_pkg.sv =====
// rbf_pkg: shared types, codes and widths for the ring buffer FIFO with peek.
// Used by ring_buffer_fifo_with_peek; no dependencies.
package rbf_pkg;

    // default sizing, handed to the top level parameters
    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // fixed field widths of the item ports
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;
    localparam int XFER_W = 32;  // write_data / read_data port width
    localparam int OFFS_W = 6;
    localparam int CNT_W  = 7;   // capacity, fill count, free slots

    // configuration port
    localparam int CFG_AW    = 3;
    localparam int CFG_DW    = 32;
    localparam int CFG_IDX_W = CFG_AW - 2;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = '0;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_GET   = 2'd1,
        CMD_PEEK  = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_BUSY    = 2'd2,
        ST_ERROR   = 2'd3
    } t_status;

    // per-item result, minus the read data
    typedef struct packed {
        t_status          status;
        logic             rd_en;
        logic [CNT_W-1:0] fill;
        logic [CNT_W-1:0] free;
        logic             empty;
        logic             full;
    } t_meta;

endpackage

// ===== src/rbf_ram.sv =====
// rbf_ram: generic single-clock RAM, one write port and one registered read port.
// No dependencies.
module rbf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/ring_buffer_fifo_with_peek.sv =====
// A command item passes stage 1, then the output register, to become a result item.
// Throughput: one item per cycle; the entry RAM is read and written at acceptance,
// pointers and count update in that same cycle, and the RAM read data lands in
// the next one. A stalled output holds the pipeline and drops the input ready.
// Reset (synchronous, active low): buffer empty, pointers zero, capacity min(64, DEPTH).
// Depends on rbf_pkg and rbf_ram.
module ring_buffer_fifo_with_peek #(
    parameter int DEPTH      = rbf_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = rbf_pkg::DATA_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rbf_pkg::CFG_AW-1:0]   paddr,
    input  logic [rbf_pkg::CFG_DW-1:0]   pwdata,
    output logic [rbf_pkg::CFG_DW-1:0]   prdata,
    output logic                         pready,
    // command items
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [rbf_pkg::CMD_W-1:0]    i_cmd,
    input  logic [rbf_pkg::XFER_W-1:0]   i_write_data,
    input  logic [rbf_pkg::OFFS_W-1:0]   i_peek_offset,
    // result items
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [rbf_pkg::STAT_W-1:0]   o_status,
    output logic [rbf_pkg::XFER_W-1:0]   o_read_data,
    output logic [rbf_pkg::CNT_W-1:0]    o_fill_count,
    output logic [rbf_pkg::CNT_W-1:0]    o_free_slots,
    output logic                         o_is_empty,
    output logic                         o_is_full
);
    import rbf_pkg::*;

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int SUM_W   = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;
    localparam int CAP_MAX = (DEPTH < 127) ? DEPTH : 127;
    localparam int CAP_RST = (DEPTH < 64) ? DEPTH : 64;

    // buffer state
    logic [CNT_W-1:0] r_cap, n_cap;
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_count, n_count;

    // pipeline: stage 1 waits on RAM data, then the output register
    logic             r_s1_valid;
    t_meta            r_s1, n_meta;
    logic             r_out_valid;
    t_meta            r_out;
    logic [XFER_W-1:0] r_out_data;

    logic             accept, s1_adv, cfg_wr;
    t_cmd             cmd;
    logic [CNT_W-1:0] cfg_val, cfg_cap;

    logic [SUM_W-1:0] wp_plus, rp_plus, peek_sum, peek_idx;
    logic [PTR_W-1:0] wp_wrap, rp_wrap;

    logic                  mem_we;
    logic [PTR_W-1:0]      mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;

    // handshakes
    assign accept     = i_in_valid && o_in_ready;
    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign cmd        = t_cmd'(i_cmd);

    // configuration write and readback
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready
                     && (paddr[CFG_AW-1:2] == REG_CAPACITY);
    assign cfg_val = pwdata[CNT_W-1:0];
    always_comb begin
        priority if (cfg_val == '0) begin
            cfg_cap = CNT_W'(1);
        end else if (cfg_val > CNT_W'(CAP_MAX)) begin
            cfg_cap = CNT_W'(CAP_MAX);
        end else begin
            cfg_cap = cfg_val;
        end
    end
    assign prdata = (paddr[CFG_AW-1:2] == REG_CAPACITY) ? CFG_DW'(r_cap) : '0;

    // pointer wrap is a compare against capacity
    assign wp_plus  = SUM_W'(r_wp) + SUM_W'(1);
    assign rp_plus  = SUM_W'(r_rp) + SUM_W'(1);
    assign wp_wrap  = (wp_plus >= SUM_W'(r_cap)) ? '0 : wp_plus[PTR_W-1:0];
    assign rp_wrap  = (rp_plus >= SUM_W'(r_cap)) ? '0 : rp_plus[PTR_W-1:0];
    assign peek_sum = SUM_W'(r_rp) + SUM_W'(i_peek_offset);
    assign peek_idx = (peek_sum >= SUM_W'(r_cap)) ? peek_sum - SUM_W'(r_cap) : peek_sum;

    // command decode and next state
    always_comb begin
        n_cap          = r_cap;
        n_wp           = r_wp;
        n_rp           = r_rp;
        n_count        = r_count;
        mem_we         = 1'b0;
        mem_raddr      = r_rp;
        n_meta.status  = ST_OK;
        n_meta.rd_en   = 1'b0;
        if (accept) begin
            unique case (cmd)
                CMD_PUT: begin
                    if (r_count >= r_cap) begin
                        n_meta.status = ST_BUSY;
                    end else begin
                        mem_we  = 1'b1;
                        n_wp    = wp_wrap;
                        n_count = r_count + CNT_W'(1);
                    end
                end
                CMD_GET: begin
                    if (r_count == '0) begin
                        n_meta.status = ST_ERROR;
                    end else begin
                        n_meta.rd_en = 1'b1;
                        n_rp         = rp_wrap;
                        n_count      = r_count - CNT_W'(1);
                    end
                end
                CMD_PEEK: begin
                    if (CNT_W'(i_peek_offset) >= r_count) begin
                        n_meta.status = ST_INVALID;
                    end else begin
                        n_meta.rd_en = 1'b1;
                        mem_raddr    = peek_idx[PTR_W-1:0];
                    end
                end
                CMD_CLEAR: begin
                    n_wp    = '0;
                    n_rp    = '0;
                    n_count = '0;
                end
            endcase
        end
        n_meta.fill  = n_count;
        n_meta.free  = r_cap - n_count;
        n_meta.empty = (n_count == '0);
        n_meta.full  = (n_count >= r_cap);
        // a capacity write empties the buffer
        if (cfg_wr) begin
            n_cap   = cfg_cap;
            n_wp    = '0;
            n_rp    = '0;
            n_count = '0;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CNT_W'(CAP_RST);
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_cap   <= n_cap;
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    // entry store
    rbf_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_wp),
        .i_wdata (DATA_WIDTH'(i_write_data)),
        .i_re    (accept && n_meta.rd_en),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_meta;
        end
        if (s1_adv) begin
            r_out      <= r_s1;
            r_out_data <= r_s1.rd_en ? XFER_W'(mem_rdata) : '0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out.status;
    assign o_read_data  = r_out_data;
    assign o_fill_count = r_out.fill;
    assign o_free_slots = r_out.free;
    assign o_is_empty   = r_out.empty;
    assign o_is_full    = r_out.full;

`ifndef NO_ASSERTIONS
    // occupancy never exceeds the capacity in use
    a_count_le_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_cap)
        else $error("fill count above capacity");

    // both pointers stay inside the capacity
    a_ptr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (SUM_W'(r_wp) < SUM_W'(r_cap)) && (SUM_W'(r_rp) < SUM_W'(r_cap)))
        else $error("pointer beyond capacity");

    // empty buffer means the pointers meet
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wp == r_rp))
        else $error("empty buffer with pointers apart");

    // a successful get removes exactly one entry
    a_get_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && cmd == CMD_GET && r_count != '0 && !cfg_wr)
        |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("get did not remove one entry");

    // a held stage 1 item blocks new items
    a_hold_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |-> !o_in_ready)
        else $error("input taken while stage 1 stalled");
`endif

endmodule
